@@ rtl/awaf_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// awaf_pkg : shared constants and types of the window average framer
// Widths, framing constants, command codes and the queued window record.
// ---------------------------------------------------------------------------
package awaf_pkg;

	localparam int COUNT_BITS   = 16;
	localparam int READING_BITS = 10;
	localparam int SUM_W        = READING_BITS + COUNT_BITS;
	localparam int MEAN_SHIFT   = 19;
	// quotient never exceeds 1023 << 19, so 29 bits hold it whatever the count width
	localparam int QUOT_W       = READING_BITS + MEAN_SHIFT;
	localparam int STEP_W       = $clog2(QUOT_W);

	localparam logic [7:0] SYNC_BIT   = 8'h80;
	localparam logic [1:0] BYTE_FIRST = 2'd0;
	localparam logic [1:0] BYTE_LAST  = 2'd3;

	localparam logic CMD_SAMPLE     = 1'b0;
	localparam logic CMD_WINDOW_END = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [SUM_W-1:0]      sum;
		logic [COUNT_BITS-1:0] count;
		logic                  sense_plus;
		logic                  sense_minus;
		logic                  battery_low;
	} win_t;

endpackage
`default_nettype wire

@@ rtl/awaf_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// awaf_front : sample accumulator
// Sums inverted readings and counts them; a window end hands the totals on.
// ---------------------------------------------------------------------------
module awaf_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 cmd,
	input  wire logic [awaf_pkg::READING_BITS-1:0]    sample,
	input  wire logic                                 sense_plus,
	input  wire logic                                 sense_minus,
	input  wire logic                                 battery_low,
	output logic                                      push_valid,
	input  wire logic                                 push_ready,
	output awaf_pkg::win_t                            push_data
);

	logic [awaf_pkg::SUM_W-1:0]        sum_q;
	logic [awaf_pkg::COUNT_BITS-1:0]   count_q;
	logic                              accept;
	logic [awaf_pkg::READING_BITS-1:0] inv_sample;

	assign in_ready   = push_ready;
	assign accept     = in_valid && push_ready;
	assign push_valid = in_valid && (cmd == awaf_pkg::CMD_WINDOW_END);

	// 1023 - reading is the bitwise inverse of a 10-bit reading
	assign inv_sample = ~sample;

	always_comb begin
		push_data.sum         = sum_q;
		push_data.count       = count_q;
		push_data.sense_plus  = sense_plus;
		push_data.sense_minus = sense_minus;
		push_data.battery_low = battery_low;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (cmd == awaf_pkg::CMD_WINDOW_END) begin
				sum_q   <= '0;
				count_q <= '0;
			end else if (count_q != '1) begin
				sum_q   <= sum_q + awaf_pkg::SUM_W'(inv_sample);
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/awaf_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// awaf_queue : short window queue
// Holds finished window totals between accumulator and divider.
// ---------------------------------------------------------------------------
module awaf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire awaf_pkg::win_t push_data,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output awaf_pkg::win_t      pop_data
);

	awaf_pkg::win_t                  entry_q [awaf_pkg::QUEUE_DEPTH];
	logic [awaf_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [awaf_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [awaf_pkg::QCNT_W-1:0]     fill_q;
	logic                            push;
	logic                            pop;

	function automatic logic [awaf_pkg::QPTR_W-1:0] next_ptr(
		input logic [awaf_pkg::QPTR_W-1:0] ptr
	);
		if (ptr == awaf_pkg::QPTR_W'(awaf_pkg::QUEUE_DEPTH - 1))
			return '0;
		return ptr + 1'b1;
	endfunction

	assign push_ready = (fill_q != awaf_pkg::QCNT_W'(awaf_pkg::QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/awaf_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// awaf_back : mean divider and packet framer
// Restoring division one quotient bit a cycle (skipped for a zero count), then four framed bytes out.
// ---------------------------------------------------------------------------
module awaf_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pop_valid,
	output logic                pop_ready,
	input  wire awaf_pkg::win_t pop_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          frame_byte,
	output logic                frame_last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SEND = 2'd2;

	localparam int CB = awaf_pkg::COUNT_BITS;
	localparam int RB = awaf_pkg::READING_BITS;

	logic [1:0]                      state_q;
	logic [CB-1:0]                   rem_q;
	logic [CB-1:0]                   div_q;
	logic [awaf_pkg::QUOT_W-1:0]     quot_q;   // dividend low bits in, quotient out
	logic [awaf_pkg::STEP_W-1:0]     step_q;
	logic [1:0]                      idx_q;
	logic                            plus_q;
	logic                            minus_q;
	logic                            batt_q;
	logic                            out_valid_q;
	logic [7:0]                      byte_q;
	logic                            last_q;

	logic [CB:0]                     trial;
	logic                            fits;
	logic                            load_out;
	logic [7:0]                      next_byte;

	assign pop_ready  = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign frame_last = last_q;

	assign trial    = {rem_q, quot_q[awaf_pkg::QUOT_W-1]};
	assign fits     = (trial >= {1'b0, div_q});
	assign load_out = (state_q == ST_SEND) && (!out_valid_q || out_ready);

	always_comb begin
		case (idx_q)
			2'd0:    next_byte = awaf_pkg::SYNC_BIT | {2'b00, quot_q[28:23]};
			2'd1:    next_byte = {1'b0, quot_q[22:16]};
			2'd2:    next_byte = {1'b0, quot_q[15:9]};
			default: next_byte = {1'b0, plus_q, minus_q, batt_q, quot_q[8:5]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			idx_q       <= awaf_pkg::BYTE_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						step_q <= '0;
						idx_q  <= awaf_pkg::BYTE_FIRST;
						state_q <= (pop_data.count == '0) ? ST_SEND : ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == awaf_pkg::STEP_W'(awaf_pkg::QUOT_W - 1))
						state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (load_out) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == awaf_pkg::BYTE_LAST)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			// top dividend bits are sum >> 10, always below the count
			rem_q   <= pop_data.sum[awaf_pkg::SUM_W-1:RB];
			div_q   <= pop_data.count;
			plus_q  <= pop_data.sense_plus;
			minus_q <= pop_data.sense_minus;
			batt_q  <= pop_data.battery_low;
			if (pop_data.count == '0)
				quot_q <= '0;
			else
				quot_q <= {pop_data.sum[RB-1:0], awaf_pkg::MEAN_SHIFT'(0)};
		end else if (state_q == ST_DIV) begin
			rem_q  <= fits ? CB'(trial - {1'b0, div_q}) : trial[CB-1:0];
			quot_q <= {quot_q[awaf_pkg::QUOT_W-2:0], fits};
		end
		if (load_out) begin
			byte_q <= next_byte;
			last_q <= (idx_q == awaf_pkg::BYTE_LAST);
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_q != '0))
		else $error("divider running with zero count");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < div_q))
		else $error("partial remainder not below divisor");

	// sync bit only on the first byte, last flag only on the fourth: never both on one byte
	a_sync_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(byte_q[7] && last_q))
		else $error("sync bit and last flag disagree");

	a_send_done: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && idx_q == awaf_pkg::BYTE_LAST) |=> (state_q == ST_IDLE))
		else $error("framer did not release after last byte");

endmodule
`default_nettype wire

@@ rtl/adc_window_average_framer_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// adc_window_average_framer_core : converter window averager and framer
// Accumulates inverted readings, divides sum << 19 by the count at window
// end and sends the mean as a four-byte packet with status bits.
// ---------------------------------------------------------------------------
//
//  channel | handshake           | words
//  --------+---------------------+----------------------------------------
//  in      | in_valid / in_ready | cmd, sample, sense_plus, sense_minus,
//          |                     | battery_low
//  out     | out_valid/out_ready | frame_byte, frame_last (4 words/window)
//
//  Flow   : a sample word is taken every cycle while the queue has room; a window
//           end pushes the totals on. The back end loads a window, divides (one
//           quotient bit a cycle, restoring divider), sends four bytes, and
//           only then takes the next window from the queue.
//  Queue  : two finished windows wait between accumulator and divider; with
//           it full, in_ready drops for every word.
//  Stalls : out_ready low holds the current byte and the framer; the
//           divider carries on only to the end of its current window.
//  Reset  : arst_n clears sum, count, queue and control; no clearing pass.
//
module adc_window_average_framer_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              cmd,
	input  wire logic [awaf_pkg::READING_BITS-1:0] sample,
	input  wire logic                              sense_plus,
	input  wire logic                              sense_minus,
	input  wire logic                              battery_low,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [7:0]                             frame_byte,
	output logic                                   frame_last
);

	// front to queue
	logic           push_valid;
	logic           push_ready;
	awaf_pkg::win_t push_data;

	// queue to back
	logic           pop_valid;
	logic           pop_ready;
	awaf_pkg::win_t pop_data;

	// accumulator: one sample word a cycle while the queue has room, window totals pushed on cmd = 1
	awaf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.sample      (sample),
		.sense_plus  (sense_plus),
		.sense_minus (sense_minus),
		.battery_low (battery_low),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	// decouples the accumulator from the slow divide
	awaf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// divider and framer with registered output word
	awaf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.frame_last (frame_last)
	);

endmodule
`default_nettype wire
